@@ rtl/multitap_text_editor_core_assert.svh @@
// Assertion macros for the multi-tap text editor.
// Used by the port checker; needs a clk and an rst_n in scope.
`ifndef MULTITAP_TEXT_EDITOR_CORE_ASSERT_SVH
`define MULTITAP_TEXT_EDITOR_CORE_ASSERT_SVH

// Check a property while out of reset.
`define MTE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mte assertion failed");

// Check a property on every edge, reset included.
`define MTE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mte assertion failed");

`endif

@@ rtl/mte_pkg.sv @@
// Shared types, command codes and the key group table of the text editor.
// No dependencies.
package mte_pkg;

  localparam int TEXT_BYTES  = 128;
  localparam int KEY_GROUPS  = 28;
  localparam int LETTER_KEYS = 13;

  localparam logic [3:0] CMD_KEY     = 4'd0;
  localparam logic [3:0] CMD_INSERT  = 4'd1;
  localparam logic [3:0] CMD_BKSP    = 4'd2;
  localparam logic [3:0] CMD_MOVE    = 4'd3;
  localparam logic [3:0] CMD_SHIFT   = 4'd4;
  localparam logic [3:0] CMD_CONFIRM = 4'd5;
  localparam logic [3:0] CMD_TICK    = 4'd6;
  localparam logic [3:0] CMD_CLEAR   = 4'd7;
  localparam logic [3:0] CMD_READ    = 4'd8;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LATCH, OP_DECODE, OP_KEY_PREP, OP_INS_CHECK, OP_BS_CHECK,
    OP_WALK_INIT, OP_WALK_TEST, OP_WALK_STEP, OP_INS_TEST, OP_INS_MOVE,
    OP_INS_WR1, OP_INS_WR2, OP_INS_FIN, OP_BS_RD, OP_BS_END, OP_BS_TEST,
    OP_BS_MOVE, OP_BS_FIN, OP_READ_DONE, OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   walk_bs;
    logic   key_mode;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic       key_bad;
    logic       rep;
    logic       ins_fail;
    logic       cur_zero;
    logic       walk_go;
    logic       ins_more;
    logic       bs_more;
  } dp_stat_t;

  function automatic logic [2:0] grp_len(input logic [4:0] k);
    logic [2:0] r;
    case (k)
      5'd0, 5'd7:                          r = 3'd6;
      5'd2, 5'd4, 5'd10, 5'd13:            r = 3'd4;
      5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
      5'd20, 5'd21, 5'd22, 5'd25:          r = 3'd2;
      5'd27:                               r = 3'd5;
      default:                             r = 3'd3;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] pick(input logic [2:0] c,
      input logic [15:0] a0, input logic [15:0] a1, input logic [15:0] a2,
      input logic [15:0] a3, input logic [15:0] a4, input logic [15:0] a5);
    logic [15:0] r;
    case (c)
      3'd1:    r = a1;
      3'd2:    r = a2;
      3'd3:    r = a3;
      3'd4:    r = a4;
      3'd5:    r = a5;
      default: r = a0;
    endcase
    return r;
  endfunction

  // Characters of each key group; two-byte codes hold lead and trail.
  function automatic logic [15:0] grp_code(input logic [4:0] k, input logic [2:0] c);
    logic [15:0] r;
    case (k)
      5'd0:  r = pick(c, 16'h61, 16'h62, 16'hC3A1, 16'hC3A0, 16'hC3A3, 16'hC3A2);
      5'd1:  r = pick(c, 16'h63, 16'h64, 16'hC3A7, 16'h0, 16'h0, 16'h0);
      5'd2:  r = pick(c, 16'h65, 16'h66, 16'hC3A9, 16'hC3AA, 16'h0, 16'h0);
      5'd3:  r = pick(c, 16'h67, 16'h68, 16'h31, 16'h0, 16'h0, 16'h0);
      5'd4:  r = pick(c, 16'h69, 16'h6A, 16'hC3AD, 16'h32, 16'h0, 16'h0);
      5'd5:  r = pick(c, 16'h6B, 16'h6C, 16'h33, 16'h0, 16'h0, 16'h0);
      5'd6:  r = pick(c, 16'h6D, 16'h6E, 16'h34, 16'h0, 16'h0, 16'h0);
      5'd7:  r = pick(c, 16'h6F, 16'h70, 16'hC3B3, 16'hC3B4, 16'hC3B5, 16'h35);
      5'd8:  r = pick(c, 16'h71, 16'h72, 16'h36, 16'h0, 16'h0, 16'h0);
      5'd9:  r = pick(c, 16'h73, 16'h74, 16'h37, 16'h0, 16'h0, 16'h0);
      5'd10: r = pick(c, 16'h75, 16'h76, 16'hC3BA, 16'h38, 16'h0, 16'h0);
      5'd11: r = pick(c, 16'h77, 16'h78, 16'h39, 16'h0, 16'h0, 16'h0);
      5'd12: r = pick(c, 16'h79, 16'h7A, 16'h30, 16'h0, 16'h0, 16'h0);
      5'd13: r = pick(c, 16'h2E, 16'h2C, 16'h3F, 16'h21, 16'h0, 16'h0);
      5'd14: r = pick(c, 16'h40, 16'h23, 16'h26, 16'h0, 16'h0, 16'h0);
      5'd15: r = pick(c, 16'h2E, 16'h2C, 16'h0, 16'h0, 16'h0, 16'h0);
      5'd16: r = pick(c, 16'h3F, 16'h21, 16'h0, 16'h0, 16'h0, 16'h0);
      5'd17: r = pick(c, 16'h3A, 16'h3B, 16'h0, 16'h0, 16'h0, 16'h0);
      5'd18: r = pick(c, 16'h22, 16'h27, 16'h0, 16'h0, 16'h0, 16'h0);
      5'd19: r = pick(c, 16'h28, 16'h29, 16'h0, 16'h0, 16'h0, 16'h0);
      5'd20: r = pick(c, 16'h5B, 16'h5D, 16'h0, 16'h0, 16'h0, 16'h0);
      5'd21: r = pick(c, 16'h7B, 16'h7D, 16'h0, 16'h0, 16'h0, 16'h0);
      5'd22: r = pick(c, 16'h3C, 16'h3E, 16'h0, 16'h0, 16'h0, 16'h0);
      5'd23: r = pick(c, 16'h2B, 16'h2D, 16'h3D, 16'h0, 16'h0, 16'h0);
      5'd24: r = pick(c, 16'h2A, 16'h2F, 16'h5C, 16'h0, 16'h0, 16'h0);
      5'd25: r = pick(c, 16'h5F, 16'h40, 16'h0, 16'h0, 16'h0, 16'h0);
      5'd26: r = pick(c, 16'h23, 16'h24, 16'h25, 16'h0, 16'h0, 16'h0);
      5'd27: r = pick(c, 16'h26, 16'h7C, 16'h7E, 16'h5E, 16'h60, 16'h0);
      default: r = 16'h0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/multitap_text_editor_core.sv @@
// Top level of the multi-tap keypad text editor: ports, config registers.
// Depends on mte_pkg, mte_ctrl and mte_dpath.
//
//   channel  | kind         | payload
//   in_      | stream slave | command item, 72-bit tdata
//   out_     | stream master| result item, 32-bit tdata
//   cfg_     | APB write/rd | tap_timeout_ms at 0, max_char_count at 4
//
// One item at a time. Simple commands pass through latch, decode and output load;
// a read adds a read-done step. Insert and backspace walk the text one character
// at a time to find the cursor, then move each byte behind it, by one read and one
// write, through the text memory. A repeated key tap deletes and then inserts.
// Reset is synchronous and needs no clearing pass. A result waiting in the output
// register stalls only the end of the next item.
module multitap_text_editor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[3:0] key_index[8:4] now_ms[40:9] char_lead[48:41] char_trail[56:49]
  // cursor_target[63:57] byte_index[70:64]
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // ok[0] cursor_pos[6:1] char_total[12:7] byte_total[19:13] tap_pending[20]
  // shift_on[21] read_value[29:22]
  output logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mte_pkg::*;

  logic [15:0] timeout_r;
  logic [5:0]  maxc_r;
  dp_cmd_t     dcmd;
  dp_stat_t    dstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 16'd1000;
      maxc_r    <= 6'd63;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2]) maxc_r <= cfg_pwdata[5:0];
      else timeout_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? {26'b0, maxc_r} : {16'b0, timeout_r};

  mte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat_i    (dstat),
    .cmd_o     (dcmd)
  );

  mte_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (dcmd),
    .stat_o    (dstat),
    .in_data   (in_tdata),
    .timeout_i (timeout_r),
    .maxc_i    (maxc_r),
    .out_data  (out_tdata)
  );

endmodule

@@ rtl/mte_ctrl.sv @@
// Sequencer of the text editor: steps the datapath through each command.
// Depends on mte_pkg.
module mte_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mte_pkg::dp_stat_t stat_i,
  output mte_pkg::dp_cmd_t  cmd_o
);
  import mte_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_KEY_PREP, S_INS_CHECK, S_BS_CHECK, S_WALK_INIT,
    S_WALK_TEST, S_WALK_STEP, S_INS_TEST, S_INS_MOVE, S_INS_WR1, S_INS_WR2,
    S_INS_FIN, S_BS_RD, S_BS_END, S_BS_TEST, S_BS_MOVE, S_BS_FIN,
    S_READ_DONE, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   walk_bs_r, walk_bs_nxt;
  logic   key_mode_r, key_mode_nxt;
  dp_op_t op;

  always_comb begin
    state_nxt    = state_r;
    walk_bs_nxt  = walk_bs_r;
    key_mode_nxt = key_mode_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    op = OP_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        op = OP_DECODE;
        key_mode_nxt = (stat_i.cmd == CMD_KEY);
        case (stat_i.cmd)
          CMD_KEY:    state_nxt = stat_i.key_bad ? S_FINISH : S_KEY_PREP;
          CMD_INSERT: state_nxt = S_INS_CHECK;
          CMD_BKSP:   state_nxt = S_BS_CHECK;
          CMD_READ:   state_nxt = S_READ_DONE;
          default:    state_nxt = S_FINISH;
        endcase
      end
      S_KEY_PREP: begin
        op = OP_KEY_PREP;
        state_nxt = stat_i.rep ? S_BS_CHECK : S_INS_CHECK;
      end
      S_INS_CHECK: begin
        op = OP_INS_CHECK;
        walk_bs_nxt = 1'b0;
        state_nxt = stat_i.ins_fail ? S_FINISH : S_WALK_INIT;
      end
      S_BS_CHECK: begin
        op = OP_BS_CHECK;
        walk_bs_nxt = 1'b1;
        if (stat_i.cur_zero) state_nxt = key_mode_r ? S_INS_CHECK : S_FINISH;
        else state_nxt = S_WALK_INIT;
      end
      S_WALK_INIT: begin
        op = OP_WALK_INIT;
        state_nxt = S_WALK_TEST;
      end
      S_WALK_TEST: begin
        op = OP_WALK_TEST;
        if (stat_i.walk_go) state_nxt = S_WALK_STEP;
        else state_nxt = walk_bs_r ? S_BS_RD : S_INS_TEST;
      end
      S_WALK_STEP: begin
        op = OP_WALK_STEP;
        state_nxt = S_WALK_TEST;
      end
      S_INS_TEST: begin
        op = OP_INS_TEST;
        state_nxt = stat_i.ins_more ? S_INS_MOVE : S_INS_WR1;
      end
      S_INS_MOVE: begin
        op = OP_INS_MOVE;
        state_nxt = S_INS_TEST;
      end
      S_INS_WR1: begin
        op = OP_INS_WR1;
        state_nxt = S_INS_WR2;
      end
      S_INS_WR2: begin
        op = OP_INS_WR2;
        state_nxt = S_INS_FIN;
      end
      S_INS_FIN: begin
        op = OP_INS_FIN;
        state_nxt = S_FINISH;
      end
      S_BS_RD: begin
        op = OP_BS_RD;
        state_nxt = S_BS_END;
      end
      S_BS_END: begin
        op = OP_BS_END;
        state_nxt = S_BS_TEST;
      end
      S_BS_TEST: begin
        op = OP_BS_TEST;
        state_nxt = stat_i.bs_more ? S_BS_MOVE : S_BS_FIN;
      end
      S_BS_MOVE: begin
        op = OP_BS_MOVE;
        state_nxt = S_BS_TEST;
      end
      S_BS_FIN: begin
        op = OP_BS_FIN;
        state_nxt = key_mode_r ? S_INS_CHECK : S_FINISH;
      end
      S_READ_DONE: begin
        op = OP_READ_DONE;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold the result until the output slot is free
        if (!out_valid_r || out_ready) begin
          op = OP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      walk_bs_r   <= 1'b0;
      key_mode_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      walk_bs_r   <= walk_bs_nxt;
      key_mode_r  <= key_mode_nxt;
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign cmd_o.op       = op;
  assign cmd_o.walk_bs  = walk_bs_r;
  assign cmd_o.key_mode = key_mode_r;

endmodule

@@ rtl/mte_dpath.sv @@
// Datapath of the text editor: text memory, editor state, work registers.
// Depends on mte_pkg; driven by mte_ctrl.
module mte_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  mte_pkg::dp_cmd_t  cmd_i,
  output mte_pkg::dp_stat_t stat_o,
  input  logic [71:0]       in_data,
  input  logic [15:0]       timeout_i,
  input  logic [5:0]        maxc_i,
  output logic [31:0]       out_data
);
  import mte_pkg::*;

  logic [7:0]  mem [TEXT_BYTES];
  logic [7:0]  rdata_r;
  logic [6:0]  raddr, waddr;
  logic [7:0]  wdata;
  logic        we;

  logic [3:0]  cmd_r;
  logic [4:0]  key_r;
  logic [31:0] now_r;
  logic [7:0]  lead_r, trail_r;
  logic [6:0]  target_r, bidx_r;

  logic [6:0]  bytes_r;
  logic [5:0]  chars_r, cursor_r;
  logic        pend_r, pshift_r, shift_r;
  logic [4:0]  pkey_r;
  logic [2:0]  cyc_r;
  logic [31:0] last_r;

  logic [7:0]  off_r;
  logic [5:0]  cnt_r, tgt_r;
  logic [6:0]  pos_r, idx_r;
  logic [1:0]  d_r;
  logic        n2_r, ok_r, letter_r, nshift_r;
  logic [2:0]  ncyc_r;
  logic [7:0]  rd_r;
  logic [31:0] out_r;

  logic        due, rep, nshift, letter, lead_ok, n2, ins_fail, walk_go;
  logic [2:0]  len, cyc_inc, ncyc;
  logic [15:0] code;
  logic [7:0]  klead, ktrail, room;
  logic [6:0]  off_clamp, endv;
  logic [1:0]  w;
  logic [7:0]  wsum;

  always_comb begin
    due     = pend_r && ((now_r - last_r) >= {16'b0, timeout_i});
    rep     = pend_r && (pkey_r == key_r);
    len     = grp_len(key_r);
    cyc_inc = cyc_r + 3'd1;
    ncyc    = rep ? ((cyc_inc >= len) ? 3'd0 : cyc_inc) : 3'd0;
    nshift  = rep ? pshift_r : shift_r;
    code    = grp_code(key_r, ncyc);
    klead   = (code[15:8] != 8'd0) ? code[15:8] : code[7:0];
    ktrail  = code[7:0];
    letter  = ({27'b0, key_r} < LETTER_KEYS);
    if (letter && nshift) begin
      if (klead >= 8'h61 && klead <= 8'h7A) klead = klead - 8'd32;
      else if (klead == 8'hC3 && ktrail >= 8'hA0) ktrail = ktrail - 8'd32;
    end
    n2 = lead_r[7];
    if (lead_r == 8'd0) lead_ok = 1'b0;
    else if (!n2) lead_ok = (lead_r == 8'd10) || (lead_r >= 8'd32 && lead_r <= 8'd126);
    else lead_ok = (lead_r == 8'hC3) && (trail_r >= 8'h80) && (trail_r <= 8'hBF);
    room     = {1'b0, bytes_r} + (n2 ? 8'd2 : 8'd1);
    ins_fail = !lead_ok || (room >= 8'(TEXT_BYTES)) || (chars_r >= maxc_i);
    walk_go  = (cnt_r < tgt_r) && (off_r < {1'b0, bytes_r});
    off_clamp = (off_r > {1'b0, bytes_r}) ? bytes_r : off_r[6:0];
    w    = rdata_r[7] ? 2'd2 : 2'd1;
    wsum = {1'b0, pos_r} + {6'b0, w};
    if (pos_r < bytes_r) endv = (wsum > {1'b0, bytes_r}) ? bytes_r : wsum[6:0];
    else endv = pos_r;
  end

  assign stat_o.cmd      = cmd_r;
  assign stat_o.key_bad  = ({27'b0, key_r} >= KEY_GROUPS);
  assign stat_o.rep      = rep;
  assign stat_o.ins_fail = ins_fail;
  assign stat_o.cur_zero = (cursor_r == 6'd0);
  assign stat_o.walk_go  = walk_go;
  assign stat_o.ins_more = (idx_r > pos_r);
  assign stat_o.bs_more  = (idx_r < bytes_r);

  always_comb begin
    raddr = off_r[6:0];
    we    = 1'b0;
    waddr = pos_r;
    wdata = rdata_r;
    case (cmd_i.op)
      OP_DECODE:  raddr = bidx_r;
      OP_INS_TEST: raddr = idx_r - 7'd1;
      OP_BS_RD:   raddr = pos_r;
      OP_BS_TEST: raddr = idx_r;
      OP_INS_MOVE: begin
        we = 1'b1;
        waddr = idx_r - 7'd1 + (n2_r ? 7'd2 : 7'd1);
      end
      OP_INS_WR1: begin
        we = 1'b1;
        wdata = lead_r;
      end
      OP_INS_WR2: begin
        we = n2_r;
        waddr = pos_r + 7'd1;
        wdata = trail_r;
      end
      OP_BS_MOVE: begin
        we = 1'b1;
        waddr = idx_r - {5'b0, d_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r  <= '0;
      chars_r  <= '0;
      cursor_r <= '0;
      pend_r   <= 1'b0;
      pkey_r   <= '0;
      cyc_r    <= '0;
      pshift_r <= 1'b0;
      shift_r  <= 1'b0;
      last_r   <= '0;
      cmd_r    <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_LATCH: begin
          cmd_r    <= in_data[3:0];
          key_r    <= in_data[8:4];
          now_r    <= in_data[40:9];
          lead_r   <= in_data[48:41];
          trail_r  <= in_data[56:49];
          target_r <= in_data[63:57];
          bidx_r   <= in_data[70:64];
          rd_r     <= 8'd0;
          ok_r     <= 1'b0;
        end
        OP_DECODE: begin
          case (cmd_r)
            CMD_KEY: begin
              if (!stat_o.key_bad && due) pend_r <= 1'b0;
            end
            CMD_TICK: begin
              if (due) pend_r <= 1'b0;
              ok_r <= due;
            end
            CMD_MOVE: begin
              pend_r <= 1'b0;
              cursor_r <= (target_r > {1'b0, chars_r}) ? chars_r : target_r[5:0];
              ok_r <= 1'b1;
            end
            CMD_SHIFT: begin
              pend_r <= 1'b0;
              shift_r <= !(shift_r || (pend_r && pshift_r));
              ok_r <= 1'b1;
            end
            CMD_CONFIRM: begin
              pend_r <= 1'b0;
              ok_r <= 1'b1;
            end
            CMD_CLEAR: begin
              bytes_r  <= '0;
              chars_r  <= '0;
              cursor_r <= '0;
              pend_r   <= 1'b0;
              pkey_r   <= '0;
              cyc_r    <= '0;
              pshift_r <= 1'b0;
              shift_r  <= 1'b0;
              last_r   <= '0;
              ok_r     <= 1'b1;
            end
            CMD_READ: ok_r <= 1'b1;
            default: ;
          endcase
        end
        OP_KEY_PREP: begin
          lead_r   <= klead;
          trail_r  <= ktrail;
          ncyc_r   <= ncyc;
          nshift_r <= nshift;
          letter_r <= letter;
        end
        OP_INS_CHECK: begin
          pend_r <= 1'b0;
          ok_r   <= 1'b0;
          n2_r   <= n2;
        end
        OP_BS_CHECK: begin
          pend_r <= 1'b0;
          ok_r   <= 1'b0;
        end
        OP_WALK_INIT: begin
          off_r <= '0;
          cnt_r <= '0;
          tgt_r <= cmd_i.walk_bs ? (cursor_r - 6'd1) : cursor_r;
        end
        OP_WALK_TEST: begin
          if (!walk_go) begin
            pos_r <= off_clamp;
            idx_r <= bytes_r;
          end
        end
        OP_WALK_STEP: begin
          off_r <= off_r + {6'b0, w};
          cnt_r <= cnt_r + 6'd1;
        end
        OP_INS_MOVE: idx_r <= idx_r - 7'd1;
        OP_INS_FIN: begin
          bytes_r  <= bytes_r + (n2_r ? 7'd2 : 7'd1);
          chars_r  <= chars_r + 6'd1;
          cursor_r <= cursor_r + 6'd1;
          ok_r     <= 1'b1;
          if (cmd_i.key_mode) begin
            pend_r   <= 1'b1;
            pkey_r   <= key_r;
            cyc_r    <= ncyc_r;
            pshift_r <= nshift_r;
            last_r   <= now_r;
            if (letter_r) shift_r <= 1'b0;
          end
        end
        OP_BS_END: begin
          idx_r <= endv;
          d_r   <= 2'(endv - pos_r);
        end
        OP_BS_MOVE: idx_r <= idx_r + 7'd1;
        OP_BS_FIN: begin
          bytes_r  <= bytes_r - {5'b0, d_r};
          if (chars_r != 6'd0) chars_r <= chars_r - 6'd1;
          cursor_r <= cursor_r - 6'd1;
          ok_r     <= 1'b1;
        end
        OP_READ_DONE: rd_r <= (bidx_r < bytes_r) ? rdata_r : 8'd0;
        OP_OUT_LOAD: begin
          out_r <= {2'b0, rd_r, shift_r, pend_r, bytes_r, chars_r, cursor_r, ok_r};
        end
        default: ;
      endcase
    end
  end

  assign out_data = out_r;

endmodule

@@ rtl/mte_checker.sv @@
// Port-level checks of the text editor and their bind to the top level.
// Depends on multitap_text_editor_core_assert.svh.
`include "multitap_text_editor_core_assert.svh"

module mte_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  `MTE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid)
  `MTE_ASSERT(a_cursor_in_text, out_tvalid |-> out_tdata[6:1] <= out_tdata[12:7])
  `MTE_ASSERT(a_bytes_span, out_tvalid |-> ({1'b0, out_tdata[12:7]} <= out_tdata[19:13]) && (out_tdata[19:13] <= {out_tdata[12:7], 1'b0}))
  `MTE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid)

endmodule

bind multitap_text_editor_core mte_checker u_mte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
